[design/dsdr_pkg.sv]
// dsdr_pkg: shared constants, codes and types of the disc splat depth renderer
// no dependencies; compiled first
package dsdr_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int X_BITS        = $clog2(MAX_WIDTH);
   localparam int Y_BITS        = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS     = X_BITS + Y_BITS;
   localparam int MEM_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_BITS      = 9;
   localparam int COORD_BITS    = 13;
   localparam int POS_BITS      = COORD_BITS + 1;
   localparam int DEPTH_BITS    = 16;
   localparam int NUM_LEVELS    = 4;
   localparam int LEVEL_BITS    = 2;
   localparam int RADIUS_BITS   = 4;
   localparam int OFFSET_BITS   = RADIUS_BITS + 1;
   localparam int SQ_BITS       = 2 * OFFSET_BITS;
   localparam int THR_BITS      = NUM_LEVELS * DEPTH_BITS;
   localparam int RADII_BITS    = NUM_LEVELS * RADIUS_BITS;
   localparam int CMD_BITS      = 2;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_SEL_LSB   = 3;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WIDTH      = 2'd0,
      REG_HEIGHT     = 2'd1,
      REG_THRESHOLDS = 2'd2,
      REG_RADII      = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEVEL,
      ST_DRAW,
      ST_READ,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]    width;
      logic [DIM_BITS-1:0]    height;
      logic [THR_BITS-1:0]    thresholds;
      logic [RADII_BITS-1:0]  radii;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic clr_step;
      logic lvl_step;
      logic draw_start;
      logic draw_step;
      logic read_issue;
      logic rsp_load;
   } ctl_type;

   typedef struct packed {
      logic clr_last;
      logic lvl_adv;
      logic draw_last;
      logic rsp_free;
   } sts_type;

endpackage

[design/dsdr_req_if.sv]
// dsdr_req_if: command channel carrying clear, draw and read items
// depends on dsdr_pkg
interface dsdr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [dsdr_pkg::CMD_BITS-1:0]          cmd;
   logic signed [dsdr_pkg::COORD_BITS-1:0] point_u;
   logic signed [dsdr_pkg::COORD_BITS-1:0] point_v;
   logic [dsdr_pkg::DEPTH_BITS-1:0]        point_depth;

   modport source (output valid, cmd, point_u, point_v, point_depth, input ready);
   modport sink   (input valid, cmd, point_u, point_v, point_depth, output ready);
endinterface

[design/dsdr_rsp_if.sv]
// dsdr_rsp_if: result channel carrying the pixel value of a read
// depends on dsdr_pkg
interface dsdr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dsdr_pkg::DEPTH_BITS-1:0] pixel_depth;

   modport source (output valid, pixel_depth, input ready);
   modport sink   (input valid, pixel_depth, output ready);
endinterface

[design/dsdr_csr.sv]
// dsdr_csr: apb-style register file for image size, level thresholds and radii
// depends on dsdr_pkg
module dsdr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dsdr_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [dsdr_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [dsdr_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready,
   output dsdr_pkg::cfg_type                  cfg
);

   logic [dsdr_pkg::DIM_BITS-1:0]   width_ff, width_in;
   logic [dsdr_pkg::DIM_BITS-1:0]   height_ff, height_in;
   logic [dsdr_pkg::THR_BITS-1:0]   thr_ff, thr_in;
   logic [dsdr_pkg::RADII_BITS-1:0] radii_ff, radii_in;
   logic                            wr_en;
   dsdr_pkg::reg_type               sel;

   assign wr_en  = psel && penable && pwrite;
   assign sel    = dsdr_pkg::reg_type'(paddr[dsdr_pkg::CSR_SEL_LSB +: 2]);
   assign pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      radii_in  = radii_ff;
      prdata    = '0;
      unique case (sel)
         dsdr_pkg::REG_WIDTH: begin
            prdata = dsdr_pkg::CSR_DATA_BITS'(width_ff);
            if (wr_en) width_in = pwdata[dsdr_pkg::DIM_BITS-1:0];
         end
         dsdr_pkg::REG_HEIGHT: begin
            prdata = dsdr_pkg::CSR_DATA_BITS'(height_ff);
            if (wr_en) height_in = pwdata[dsdr_pkg::DIM_BITS-1:0];
         end
         dsdr_pkg::REG_THRESHOLDS: begin
            prdata = dsdr_pkg::CSR_DATA_BITS'(thr_ff);
            if (wr_en) thr_in = pwdata[dsdr_pkg::THR_BITS-1:0];
         end
         dsdr_pkg::REG_RADII: begin
            prdata = dsdr_pkg::CSR_DATA_BITS'(radii_ff);
            if (wr_en) radii_in = pwdata[dsdr_pkg::RADII_BITS-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dsdr_pkg::DIM_BITS'(dsdr_pkg::MAX_WIDTH);
         height_ff <= dsdr_pkg::DIM_BITS'(dsdr_pkg::MAX_HEIGHT);
         thr_ff    <= '0;
         radii_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
         radii_ff  <= radii_in;
      end
   end

   assign cfg.width      = width_ff;
   assign cfg.height     = height_ff;
   assign cfg.thresholds = thr_ff;
   assign cfg.radii      = radii_ff;

endmodule

[design/dsdr_ctrl.sv]
// dsdr_ctrl: sequencer for clearing pass, level search, disc sweep and pixel read
// depends on dsdr_pkg
module dsdr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [dsdr_pkg::CMD_BITS-1:0] req_cmd,
   output logic                          req_ready,
   input  dsdr_pkg::sts_type             sts,
   output dsdr_pkg::ctl_type             ctl,
   output dsdr_pkg::state_type           state
);

   dsdr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsdr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dsdr_pkg::ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) state_in = dsdr_pkg::ST_IDLE;
         end
         dsdr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_item = 1'b1;
               unique case (dsdr_pkg::cmd_type'(req_cmd))
                  dsdr_pkg::CMD_CLEAR: state_in = dsdr_pkg::ST_CLEAR;
                  dsdr_pkg::CMD_DRAW:  state_in = dsdr_pkg::ST_LEVEL;
                  dsdr_pkg::CMD_READ:  state_in = dsdr_pkg::ST_READ;
                  default:             state_in = dsdr_pkg::ST_IDLE;
               endcase
            end
         end
         dsdr_pkg::ST_LEVEL: begin
            if (sts.lvl_adv) begin
               ctl.lvl_step = 1'b1;
            end else begin
               ctl.draw_start = 1'b1;
               state_in       = dsdr_pkg::ST_DRAW;
            end
         end
         dsdr_pkg::ST_DRAW: begin
            ctl.draw_step = 1'b1;
            if (sts.draw_last) state_in = dsdr_pkg::ST_IDLE;
         end
         dsdr_pkg::ST_READ: begin
            ctl.read_issue = 1'b1;
            state_in       = dsdr_pkg::ST_RESULT;
         end
         dsdr_pkg::ST_RESULT: begin
            if (sts.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = dsdr_pkg::ST_IDLE;
            end
         end
         default: state_in = dsdr_pkg::ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

[design/dsdr_datapath.sv]
// dsdr_datapath: item registers, level pointer, disc sweep counters, image memory
// and result register; depends on dsdr_pkg
module dsdr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dsdr_pkg::ctl_type                    ctl,
   output dsdr_pkg::sts_type                    sts,
   input  dsdr_pkg::cfg_type                    cfg,
   input  logic [dsdr_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic signed [dsdr_pkg::COORD_BITS-1:0] req_point_u,
   input  logic signed [dsdr_pkg::COORD_BITS-1:0] req_point_v,
   input  logic [dsdr_pkg::DEPTH_BITS-1:0]      req_point_depth,
   output logic                                 rsp_valid,
   output logic [dsdr_pkg::DEPTH_BITS-1:0]      rsp_pixel_depth,
   input  logic                                 rsp_ready
);

   localparam int PB = dsdr_pkg::POS_BITS;
   localparam int OB = dsdr_pkg::OFFSET_BITS;

   logic [dsdr_pkg::DEPTH_BITS-1:0] mem [dsdr_pkg::MEM_DEPTH];

   logic signed [dsdr_pkg::COORD_BITS-1:0] u_ff, v_ff;
   logic [dsdr_pkg::DEPTH_BITS-1:0]        depth_ff;
   logic [dsdr_pkg::LEVEL_BITS-1:0]        level_ff, level_in;
   logic [dsdr_pkg::ADDR_BITS-1:0]         clr_ff, clr_in;
   logic [dsdr_pkg::RADIUS_BITS-1:0]       radius_ff;
   logic signed [OB-1:0]                   i_ff, i_in, j_ff, j_in;
   logic [dsdr_pkg::DEPTH_BITS-1:0]        rd_data_ff;
   logic                                   inb_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [dsdr_pkg::DEPTH_BITS-1:0]        rsp_data_ff;

   logic [dsdr_pkg::DEPTH_BITS-1:0]        thr;
   logic [dsdr_pkg::RADIUS_BITS-1:0]       radius;
   logic signed [OB-1:0]                   r_pos, r_neg, rf_pos;
   logic [dsdr_pkg::DIM_BITS-1:0]          w_eff, h_eff;
   logic signed [PB-1:0]                   pos_x, pos_y;
   logic                                   x_in, y_in, in_img, in_disc;
   logic signed [dsdr_pkg::SQ_BITS-1:0]    ii, jj;
   logic [dsdr_pkg::SQ_BITS-1:0]           sq_sum;
   logic [2*dsdr_pkg::RADIUS_BITS-1:0]     rr;
   logic [dsdr_pkg::ADDR_BITS-1:0]         pix_addr, wr_addr;
   logic [dsdr_pkg::DEPTH_BITS-1:0]        wr_data;
   logic                                   wr_en;

   // level lookup
   assign thr    = cfg.thresholds[{level_ff, 4'b0000} +: dsdr_pkg::DEPTH_BITS];
   assign radius = cfg.radii[{level_ff, 2'b00} +: dsdr_pkg::RADIUS_BITS];
   assign r_pos  = signed'({1'b0, radius});
   assign r_neg  = -r_pos;
   assign rf_pos = signed'({1'b0, radius_ff});

   assign w_eff = (cfg.width > dsdr_pkg::DIM_BITS'(dsdr_pkg::MAX_WIDTH)) ?
                  dsdr_pkg::DIM_BITS'(dsdr_pkg::MAX_WIDTH) : cfg.width;
   assign h_eff = (cfg.height > dsdr_pkg::DIM_BITS'(dsdr_pkg::MAX_HEIGHT)) ?
                  dsdr_pkg::DIM_BITS'(dsdr_pkg::MAX_HEIGHT) : cfg.height;

   // current pixel of the sweep
   assign pos_x  = PB'(u_ff) + PB'(i_ff);
   assign pos_y  = PB'(v_ff) + PB'(j_ff);
   assign x_in   = !pos_x[PB-1] && (pos_x[PB-2:0] < (PB-1)'(w_eff));
   assign y_in   = !pos_y[PB-1] && (pos_y[PB-2:0] < (PB-1)'(h_eff));
   assign in_img = x_in && y_in;

   assign ii      = dsdr_pkg::SQ_BITS'(i_ff) * dsdr_pkg::SQ_BITS'(i_ff);
   assign jj      = dsdr_pkg::SQ_BITS'(j_ff) * dsdr_pkg::SQ_BITS'(j_ff);
   assign sq_sum  = dsdr_pkg::SQ_BITS'(ii) + dsdr_pkg::SQ_BITS'(jj);
   assign rr      = (2*dsdr_pkg::RADIUS_BITS)'(radius_ff) *
                    (2*dsdr_pkg::RADIUS_BITS)'(radius_ff);
   assign in_disc = sq_sum <= dsdr_pkg::SQ_BITS'(rr);

   assign pix_addr = {pos_y[dsdr_pkg::Y_BITS-1:0], pos_x[dsdr_pkg::X_BITS-1:0]};

   assign wr_en   = ctl.clr_step || (ctl.draw_step && in_img && in_disc);
   assign wr_addr = ctl.clr_step ? clr_ff : pix_addr;
   assign wr_data = ctl.clr_step ? '0 : depth_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (ctl.read_issue) begin
         rd_data_ff <= mem[pix_addr];
         inb_ff     <= in_img;
      end
   end

   // item, sweep and payload registers
   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         u_ff     <= req_point_u;
         v_ff     <= req_point_v;
         depth_ff <= req_point_depth;
      end
      if (ctl.draw_start) radius_ff <= radius;
      if (ctl.load_item) begin
         radius_ff <= '0;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      if (ctl.rsp_load) rsp_data_ff <= inb_ff ? rd_data_ff : '0;
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      priority if (ctl.load_item) begin
         i_in = '0;
         j_in = '0;
      end else if (ctl.draw_start) begin
         i_in = r_neg;
         j_in = r_neg;
      end else if (ctl.draw_step) begin
         if (j_ff == rf_pos) begin
            j_in = -rf_pos;
            i_in = i_ff + OB'(1);
         end else begin
            j_in = j_ff + OB'(1);
         end
      end
   end

   always_comb begin
      level_in = level_ff;
      priority if (ctl.load_item &&
                   dsdr_pkg::cmd_type'(req_cmd) == dsdr_pkg::CMD_CLEAR) begin
         level_in = '0;
      end else if (ctl.lvl_step) begin
         level_in = level_ff + dsdr_pkg::LEVEL_BITS'(1);
      end
   end

   always_comb begin
      clr_in = clr_ff;
      priority if (ctl.load_item) clr_in = '0;
      else if (ctl.clr_step) clr_in = clr_ff + dsdr_pkg::ADDR_BITS'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (ctl.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.clr_last  = clr_ff == {dsdr_pkg::ADDR_BITS{1'b1}};
   assign sts.lvl_adv   = (level_ff != dsdr_pkg::LEVEL_BITS'(dsdr_pkg::NUM_LEVELS - 1)) &&
                          (depth_ff < thr);
   assign sts.draw_last = (i_ff == rf_pos) && (j_ff == rf_pos);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_depth = rsp_data_ff;

endmodule

[design/disc_splat_depth_render.sv]
// disc_splat_depth_render: top level joining register port, sequencer and datapath
// depends on dsdr_pkg, dsdr_req_if, dsdr_rsp_if, dsdr_csr, dsdr_ctrl, dsdr_datapath
// Splats points into a 256 x 256 depth image held in a single-port-write,
// single-port-read memory that writes one pixel per clock. After reset the block
// runs a clearing pass over the memory and takes no command until it is done;
// register writes are taken throughout. A clear command runs the same clearing
// pass. A draw command is accepted, then the depth-level pointer steps (one level
// per cycle) and then the sweep covers the bounding square of a disc of radius r,
// one pixel per cycle. A read first registers the memory word and then, once the
// result register is free, loads the result register, which holds the result
// while the next command is accepted.
module disc_splat_depth_render (
   input  logic                               clock,
   input  logic                               reset,
   dsdr_req_if.sink                           req_chan,
   dsdr_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dsdr_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [dsdr_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [dsdr_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   dsdr_pkg::cfg_type   cfg;
   dsdr_pkg::ctl_type   ctl;
   dsdr_pkg::sts_type   sts;
   dsdr_pkg::state_type state;

   dsdr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dsdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .ctl       (ctl),
      .state     (state)
   );

   dsdr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .cfg             (cfg),
      .req_cmd         (req_chan.cmd),
      .req_point_u     (req_chan.point_u),
      .req_point_v     (req_chan.point_v),
      .req_point_depth (req_chan.point_depth),
      .rsp_valid       (rsp_chan.valid),
      .rsp_pixel_depth (rsp_chan.pixel_depth),
      .rsp_ready       (rsp_chan.ready)
   );

   // no command transfer while the memory is being cleared or a disc is swept
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state == dsdr_pkg::ST_CLEAR || state == dsdr_pkg::ST_DRAW) |-> !req_chan.ready)
      else $error("command accepted while busy");

   // a new result only follows a read
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state == dsdr_pkg::ST_RESULT))
      else $error("result without a read");

   // the sweep ends back in idle
   a_draw_exit: assert property (@(posedge clock) disable iff (reset)
      (state == dsdr_pkg::ST_DRAW && sts.draw_last) |=> state == dsdr_pkg::ST_IDLE)
      else $error("disc sweep did not return to idle");

endmodule
